FILE: design/fspa_pkg.sv
// fspa_pkg: shared types, status codes and a count clamp helper for the fixed slot pool allocator
// used by fspa_cfg, fspa_store and fixed_slot_pool_allocator
// no dependencies
package fspa_pkg;

  // width of the slot index field and of internal store addresses
  localparam int IDX_W = 16;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [1:0] REG_NODE_TAG   = 2'd1;
  localparam logic [1:0] REG_CHUNK_SIZE = 2'd2;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

  localparam logic [8:0] COUNT_AT_RESET = 9'd256;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_slot;
    logic [15:0] handle_tag;
    logic [15:0] slot_bytes;
    logic [8:0]  free_slots;
    logic        became_full;
    logic        became_available;
    logic        became_empty;
  } rsp_t;

  typedef struct packed {
    logic [8:0]  slot_count;
    logic [15:0] node_tag;
    logic [15:0] chunk_size;
  } cfg_t;

  // memory access bundle from the controller to the slot store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] mark_raddr;
    logic [IDX_W-1:0] queue_raddr;
    logic             mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_wdata;
    logic             queue_we;
    logic [IDX_W-1:0] queue_waddr;
    logic [IDX_W-1:0] queue_wdata;
  } store_req_t;

  // slot count as written, forced into 1..slots
  function automatic logic [8:0] clamp_count(input logic [8:0] v, input int unsigned slots);
    logic [8:0] c;
    c = (v == 9'd0) ? 9'd1 : v;
    if (32'(c) > slots) c = 9'(slots);
    return c;
  endfunction

endpackage

FILE: design/fspa_cfg.sv
// fspa_cfg: configuration registers of the slot pool allocator
// clamps the slot count and flags a pool clear on every slot count write
// depends on fspa_pkg
module fspa_cfg #(
  parameter int SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output fspa_pkg::cfg_t      cfg,
  output logic                clear
);

  localparam logic [8:0] RESET_COUNT =
    fspa_pkg::clamp_count(fspa_pkg::COUNT_AT_RESET, SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count <= RESET_COUNT;
      cfg.node_tag   <= '0;
      cfg.chunk_size <= '0;
      clear          <= 1'b0;
    end else begin
      clear <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          fspa_pkg::REG_SLOT_COUNT: begin
            cfg.slot_count <= fspa_pkg::clamp_count(cfg_data[8:0], SLOTS);
            clear          <= 1'b1;
          end
          fspa_pkg::REG_NODE_TAG:   cfg.node_tag   <= cfg_data;
          fspa_pkg::REG_CHUNK_SIZE: cfg.chunk_size <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: design/fspa_store.sv
// fspa_store: slot state memories of the pool allocator
// holds the allocated marks and the recycle queue, registered reads
// depends on fspa_pkg
module fspa_store #(
  parameter int SLOTS = 256
) (
  input  logic                          clk,
  input  fspa_pkg::store_req_t          req,
  output logic                          mark_rd,
  output logic [fspa_pkg::IDX_W-1:0]    queue_rd
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic          mark_mem  [SLOTS];
  logic [IW-1:0] queue_mem [SLOTS];
  logic [IW-1:0] queue_q;

  always_ff @(posedge clk) begin
    if (req.mark_we) mark_mem[req.mark_waddr[IW-1:0]] <= req.mark_wdata;
    if (req.rd_en) mark_rd <= mark_mem[req.mark_raddr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.queue_we) queue_mem[req.queue_waddr[IW-1:0]] <= req.queue_wdata[IW-1:0];
    if (req.rd_en) queue_q <= queue_mem[req.queue_raddr[IW-1:0]];
  end

  assign queue_rd = fspa_pkg::IDX_W'(queue_q);

endmodule

FILE: design/fixed_slot_pool_allocator.sv
// fixed_slot_pool_allocator: pool allocator of fixed-size slots, top level
// request control, free list pointers and result register
// depends on fspa_pkg, fspa_cfg, fspa_store
//
// The slot's allocated mark and the recycle queue head are read out of the memories at the
// transfer edge. In the next cycle the request is decided; both memories are written back and
// the result register is loaded once that register is free or drains. A new request is taken
// the cycle after write back, so no request is accepted while another is in progress, though a
// result may still wait in the output register. A request stalls before write back for as long
// as an earlier result is held by the receiver. Fresh slots are handed out in index order before
// recycled ones, which come back in the order they were freed. Marks of slots at or above the
// fresh pointer are treated as clear, so a slot count write clears the pool on the cycle after
// the write, with no sweep. Configuration writes are taken every cycle and belong in idle time.
module fixed_slot_pool_allocator #(
  parameter int SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  fspa_pkg::req_t     req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output fspa_pkg::rsp_t     rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [8:0] RESET_COUNT =
    fspa_pkg::clamp_count(fspa_pkg::COUNT_AT_RESET, SLOTS);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  fspa_pkg::cfg_t       cfg;
  logic                 clear;
  fspa_pkg::store_req_t store_req;
  logic                 mark_rd;
  logic [15:0]          queue_rd;

  logic [0:0]    state, state_next;
  fspa_pkg::req_t cur;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [8:0]    fill, fill_next;
  logic [8:0]    fresh, fresh_next;
  logic [8:0]    free_total, free_total_next;

  fspa_pkg::rsp_t result;
  logic           alloc_ok, free_ok, done;
  logic [15:0]    slot;
  logic [15:0]    count_ext;

  fspa_cfg #(.SLOTS(SLOTS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clear     (clear)
  );

  fspa_store #(.SLOTS(SLOTS)) u_store (
    .clk      (clk),
    .req      (store_req),
    .mark_rd  (mark_rd),
    .queue_rd (queue_rd)
  );

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  // result register is free or drains this cycle
  assign done = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign count_ext = 16'(cfg.slot_count);

  always_comb begin
    alloc_ok        = 1'b0;
    free_ok         = 1'b0;
    slot            = '0;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    fresh_next      = fresh;
    free_total_next = free_total;
    result          = '0;
    result.handle_tag = cfg.node_tag;
    result.slot_bytes = cfg.chunk_size;

    if (cur.opcode == fspa_pkg::OP_ALLOC) begin
      if (free_total == 9'd0) begin
        result.status = fspa_pkg::STAT_NO_SLOT;
      end else begin
        alloc_ok = 1'b1;
        result.status = fspa_pkg::STAT_OK;
        if (fresh < cfg.slot_count) begin
          slot       = 16'(fresh);
          fresh_next = fresh + 9'd1;
        end else begin
          slot      = queue_rd;
          head_next = (head == LAST_SLOT) ? '0 : head + IW'(1);
          fill_next = fill - 9'd1;
        end
        free_total_next    = free_total - 9'd1;
        result.became_full = (free_total == 9'd1);
      end
    end else begin
      if (cur.slot_index >= count_ext) begin
        result.status = fspa_pkg::STAT_RANGE;
      end else if (!((cur.slot_index < 16'(fresh)) && mark_rd)) begin
        // slots at or above the fresh pointer were never handed out since the last clear
        result.status = fspa_pkg::STAT_NOT_ALLOC;
        slot = cur.slot_index;
      end else begin
        free_ok = 1'b1;
        result.status = fspa_pkg::STAT_OK;
        slot            = cur.slot_index;
        tail_next       = (tail == LAST_SLOT) ? '0 : tail + IW'(1);
        fill_next       = fill + 9'd1;
        free_total_next = free_total + 9'd1;
        result.became_available = (free_total == 9'd0);
        result.became_empty     = (free_total != 9'd0) &&
                                  (free_total + 9'd1 == cfg.slot_count);
      end
    end
    result.granted_slot = slot[7:0];
    result.free_slots   = free_total_next;
  end

  always_comb begin
    store_req             = '0;
    store_req.rd_en       = req_valid && req_ready;
    store_req.mark_raddr  = req.slot_index;
    store_req.queue_raddr = 16'(head);
    store_req.mark_we     = done && (alloc_ok || free_ok);
    store_req.mark_waddr  = slot;
    store_req.mark_wdata  = alloc_ok;
    store_req.queue_we    = done && free_ok;
    store_req.queue_waddr = 16'(tail);
    store_req.queue_wdata = cur.slot_index;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_EXEC;
      S_EXEC:  if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) cur <= req;
    if (done) rsp <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      fresh      <= '0;
      free_total <= RESET_COUNT;
    end else begin
      state <= state_next;
      if (done) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (clear) begin
        head       <= '0;
        tail       <= '0;
        fill       <= '0;
        fresh      <= '0;
        free_total <= cfg.slot_count;
      end else if (done) begin
        head       <= head_next;
        tail       <= tail_next;
        fill       <= fill_next;
        fresh      <= fresh_next;
        free_total <= free_total_next;
      end
    end
  end

`ifndef SYNTHESIS
  // free count is untouched fresh slots plus queued ones; the new slot count is registered ahead of the clear
  assert property (@(posedge clk) disable iff (rst || clear)
    ({1'b0, free_total} + {1'b0, fresh}) == ({1'b0, cfg.slot_count} + {1'b0, fill}))
    else $error("free count out of step with fresh pointer and queue fill");

  assert property (@(posedge clk) disable iff (rst || clear) fresh <= cfg.slot_count)
    else $error("fresh pointer beyond slot count");

  // a request in progress keeps its operands until it is written back
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && !done |=> (state == S_EXEC) && $stable(cur))
    else $error("request dropped or changed before write back");

  // every written-back request leaves a result for the next cycle
  assert property (@(posedge clk) disable iff (rst) done |=> rsp_valid)
    else $error("result lost on write back");

  // queue is never popped when empty
  assert property (@(posedge clk) disable iff (rst)
    done && alloc_ok && !(fresh < cfg.slot_count) |-> fill != 9'd0)
    else $error("recycle queue read while empty");
`endif

endmodule
